[rtl/tzl_pkg.sv]
package tzl_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned SEC_W    = 64;
  localparam int unsigned OFF_W    = 18;
  localparam int unsigned TIDX_W   = 4;
  localparam int unsigned STATUS_W = 2;

  // item operations
  localparam logic [OP_W-1:0] OP_ADD_TYPE       = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD_TRANSITION = 2'd1;
  localparam logic [OP_W-1:0] OP_UTC_TO_LOCAL   = 2'd2;
  localparam logic [OP_W-1:0] OP_LOCAL_TO_UTC   = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_TYPE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_TYPES = 2'd3;

  // one transition table entry
  typedef struct packed {
    logic [SEC_W-1:0]  utc_secs;
    logic [SEC_W-1:0]  loc_secs;
    logic [TIDX_W-1:0] ttype;
  } trans_entry_t;

  function automatic logic [SEC_W-1:0] sext_off(input logic [OFF_W-1:0] v);
    return {{(SEC_W-OFF_W){v[OFF_W-1]}}, v};
  endfunction

endpackage

[rtl/tzl_if.sv]
interface tzl_in_if
  import tzl_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [SEC_W-1:0]  seconds;
  logic [OFF_W-1:0]  zone_offset;
  logic [TIDX_W-1:0] type_index;
  logic              post_transition;

  modport source (
    output valid, op, seconds, zone_offset, type_index, post_transition,
    input  ready
  );
  modport sink (
    input  valid, op, seconds, zone_offset, type_index, post_transition,
    output ready
  );
endinterface

interface tzl_out_if
  import tzl_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SEC_W-1:0]    result_seconds;
  logic [OFF_W-1:0]    found_offset;

  modport source (
    output valid, status, result_seconds, found_offset,
    input  ready
  );
  modport sink (
    input  valid, status, result_seconds, found_offset,
    output ready
  );
endinterface

[rtl/tzl_ram.sv]
module tzl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/timezone_transition_lookup.sv]
// time zone transition lookup
//
// channels: in_i takes one item (op, seconds, zone_offset, type_index,
// post_transition) when valid and ready are both high; out_o gives exactly
// one result item (status, result_seconds, found_offset) per input item.
// an item adds an offset type, adds a transition, or converts utc seconds
// to local seconds or back.
//
// the block works on one item at a time. a query binary-searches the stored
// transitions unless none is stored or it falls before the first; the search
// does one probe per cycle on the transition memory's single read port. local
// to utc may need more lookups after it than utc to local, and every later
// lookup waits for its registered memory read. in_i is ready again as the
// result shows.
//
// the output register holds a finished result; the block already takes the
// next item while that result waits, and stalls the new result until the
// register is taken. reset clears both table counts; memory contents are
// left as they are and only written entries are ever read.
module timezone_transition_lookup
  import tzl_pkg::*;
#(
  parameter int unsigned MAX_TYPES       = 16,
  parameter int unsigned MAX_TRANSITIONS = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tzl_in_if.sink     in_i,
  tzl_out_if.source  out_o
);

  localparam int unsigned TW  = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
  localparam int unsigned TCW = $clog2(MAX_TYPES + 1);
  localparam int unsigned NW  = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
  localparam int unsigned NCW = $clog2(MAX_TRANSITIONS + 1);

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_TRANS_WR = 4'd2;
  localparam logic [3:0] S_FIRST    = 4'd3;
  localparam logic [3:0] S_SEARCH   = 4'd4;
  localparam logic [3:0] S_L_P      = 4'd5;
  localparam logic [3:0] S_L_IDX    = 4'd6;
  localparam logic [3:0] S_L_CMP1   = 4'd7;
  localparam logic [3:0] S_L_PM1    = 4'd8;
  localparam logic [3:0] S_L_OFF2   = 4'd9;
  localparam logic [3:0] S_L_CMP2   = 4'd10;
  localparam logic [3:0] S_GET_TYPE = 4'd11;
  localparam logic [3:0] S_FINAL    = 4'd12;
  localparam logic [3:0] S_DONE     = 4'd13;

  logic [3:0]          state_q, state_d;
  logic [TCW-1:0]      type_count_q, type_count_d;
  logic [NCW-1:0]      trans_count_q, trans_count_d;

  // latched item
  logic [OP_W-1:0]     op_q;
  logic [SEC_W-1:0]    secs_q;
  logic [OFF_W-1:0]    uoff_q;
  logic [TIDX_W-1:0]   ti_q;
  logic                post_q;

  // search and resolve registers
  logic [NCW-1:0]      lo_q, lo_d;
  logic [NCW-1:0]      len_q, len_d;
  logic [TIDX_W-1:0]   type_p_q, type_p_d;
  logic [SEC_W-1:0]    utc_p_q, utc_p_d;
  logic [TIDX_W-1:0]   type_idx_q, type_idx_d;
  logic [TIDX_W-1:0]   prior_type_q, prior_type_d;
  logic [SEC_W-1:0]    ps_q, ps_d;

  // result waiting for the output register
  logic [STATUS_W-1:0] status_q, status_d;
  logic [SEC_W-1:0]    res_q, res_d;
  logic [OFF_W-1:0]    off_q, off_d;

  // output register
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [SEC_W-1:0]    out_res_q;
  logic [OFF_W-1:0]    out_off_q;
  logic                out_load;

  // memory ports
  logic                type_we, type_re;
  logic [TW-1:0]       type_waddr, type_raddr;
  logic [OFF_W-1:0]    type_rdata;
  logic                tr_we, tr_re;
  logic [NW-1:0]       tr_waddr, tr_raddr;
  trans_entry_t        tr_wdata, tr_rdata;

  logic                in_accept;
  logic                is_utc_q;
  logic [SEC_W-1:0]    key;
  logic                key_gt;      // query seconds below the probed key
  logic [NCW-1:0]      half, mid, nlo, nlen, nmid;
  logic [NCW-1:0]      nlo_m1, lo_m1, lo_m2, cnt_m1;
  logic [TCW+TIDX_W-1:0] ti_ext, tc_ext;
  logic [SEC_W-1:0]    off_ext;

  assign in_accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  assign is_utc_q = (op_q == OP_UTC_TO_LOCAL);
  assign key      = is_utc_q ? tr_rdata.utc_secs : tr_rdata.loc_secs;
  assign key_gt   = $signed(secs_q) < $signed(key);
  assign off_ext  = sext_off(type_rdata);

  // one halving step of the upper-bound search
  assign half   = len_q >> 1;
  assign mid    = lo_q + half;
  assign nlo    = key_gt ? lo_q : (mid + NCW'(1));
  assign nlen   = key_gt ? half : (len_q - half - NCW'(1));
  assign nmid   = nlo + (nlen >> 1);
  assign nlo_m1 = nlo - NCW'(1);
  assign lo_m1  = lo_q - NCW'(1);
  assign lo_m2  = lo_q - NCW'(2);
  assign cnt_m1 = trans_count_q - NCW'(1);

  assign ti_ext = {{TCW{1'b0}}, ti_q};
  assign tc_ext = {{TIDX_W{1'b0}}, type_count_q};

  always_comb begin
    state_d       = state_q;
    type_count_d  = type_count_q;
    trans_count_d = trans_count_q;
    lo_d          = lo_q;
    len_d         = len_q;
    type_p_d      = type_p_q;
    utc_p_d       = utc_p_q;
    type_idx_d    = type_idx_q;
    prior_type_d  = prior_type_q;
    ps_d          = ps_q;
    status_d      = status_q;
    res_d         = res_q;
    off_d         = off_q;

    type_we    = 1'b0;
    type_waddr = type_count_q[TW-1:0];
    type_re    = 1'b0;
    type_raddr = '0;
    tr_we      = 1'b0;
    tr_waddr   = trans_count_q[NW-1:0];
    tr_wdata   = '{utc_secs: secs_q, loc_secs: secs_q + off_ext, ttype: ti_q};
    tr_re      = 1'b0;
    tr_raddr   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        status_d = ST_OK;
        res_d    = '0;
        off_d    = '0;
        case (op_q)
          OP_ADD_TYPE: begin
            if (type_count_q == TCW'(MAX_TYPES)) begin
              status_d = ST_FULL;
            end else begin
              type_we      = 1'b1;
              type_count_d = type_count_q + TCW'(1);
            end
            state_d = S_DONE;
          end
          OP_ADD_TRANSITION: begin
            if (ti_ext >= tc_ext) begin
              status_d = ST_BAD_TYPE;
              state_d  = S_DONE;
            end else if (trans_count_q == NCW'(MAX_TRANSITIONS)) begin
              status_d = ST_FULL;
              state_d  = S_DONE;
            end else begin
              // fetch the new type's offset for the local time
              type_re    = 1'b1;
              type_raddr = TW'(ti_q);
              state_d    = S_TRANS_WR;
            end
          end
          default: begin
            if (type_count_q == '0) begin
              status_d = ST_NO_TYPES;
              state_d  = S_DONE;
            end else if (trans_count_q == '0) begin
              type_re = 1'b1;
              state_d = S_FINAL;
            end else begin
              tr_re   = 1'b1;
              state_d = S_FIRST;
            end
          end
        endcase
      end

      S_TRANS_WR: begin
        tr_we         = 1'b1;
        trans_count_d = trans_count_q + NCW'(1);
        state_d       = S_DONE;
      end

      S_FIRST: begin
        // before the first transition type 0 applies
        if (key_gt) begin
          type_re = 1'b1;
          state_d = S_FINAL;
        end else begin
          lo_d     = '0;
          len_d    = trans_count_q;
          tr_re    = 1'b1;
          tr_raddr = NW'(trans_count_q >> 1);
          state_d  = S_SEARCH;
        end
      end

      S_SEARCH: begin
        lo_d  = nlo;
        len_d = nlen;
        if (nlen != '0) begin
          tr_re    = 1'b1;
          tr_raddr = nmid[NW-1:0];
        end else if (nlo == '0) begin
          type_re = 1'b1;
          state_d = S_FINAL;
        end else if (is_utc_q) begin
          tr_re    = 1'b1;
          tr_raddr = nlo_m1[NW-1:0];
          state_d  = S_GET_TYPE;
        end else if (nlo >= trans_count_q) begin
          // past the last transition
          tr_re    = 1'b1;
          tr_raddr = cnt_m1[NW-1:0];
          state_d  = S_GET_TYPE;
        end else begin
          tr_re    = 1'b1;
          tr_raddr = nlo_m1[NW-1:0];
          state_d  = S_L_P;
        end
      end

      S_L_P: begin
        // entry p = idx - 1 governs unless the local time is skipped or repeated
        type_p_d   = tr_rdata.ttype;
        utc_p_d    = tr_rdata.utc_secs;
        type_re    = 1'b1;
        type_raddr = TW'(tr_rdata.ttype);
        tr_re      = 1'b1;
        tr_raddr   = lo_q[NW-1:0];
        state_d    = S_L_IDX;
      end

      S_L_IDX: begin
        // last local second before transition idx, under type p
        type_idx_d = tr_rdata.ttype;
        ps_d       = tr_rdata.utc_secs - SEC_W'(1) + off_ext;
        state_d    = S_L_CMP1;
      end

      S_L_CMP1: begin
        if ($signed(ps_q) < $signed(secs_q)) begin
          // local time falls in the gap before transition idx
          type_re    = 1'b1;
          type_raddr = TW'(post_q ? type_idx_q : type_p_q);
          state_d    = S_FINAL;
        end else if (lo_m1 != '0) begin
          tr_re    = 1'b1;
          tr_raddr = lo_m2[NW-1:0];
          state_d  = S_L_PM1;
        end else begin
          type_re    = 1'b1;
          type_raddr = TW'(type_p_q);
          state_d    = S_FINAL;
        end
      end

      S_L_PM1: begin
        prior_type_d = tr_rdata.ttype;
        type_re      = 1'b1;
        type_raddr   = TW'(tr_rdata.ttype);
        state_d      = S_L_OFF2;
      end

      S_L_OFF2: begin
        // last local second before transition p, under the type before it
        ps_d    = utc_p_q - SEC_W'(1) + off_ext;
        state_d = S_L_CMP2;
      end

      S_L_CMP2: begin
        type_re = 1'b1;
        if (!($signed(ps_q) < $signed(secs_q))) begin
          // repeated local time
          type_raddr = TW'(post_q ? type_p_q : prior_type_q);
        end else begin
          type_raddr = TW'(type_p_q);
        end
        state_d = S_FINAL;
      end

      S_GET_TYPE: begin
        type_re    = 1'b1;
        type_raddr = TW'(tr_rdata.ttype);
        state_d    = S_FINAL;
      end

      S_FINAL: begin
        status_d = ST_OK;
        off_d    = type_rdata;
        res_d    = is_utc_q ? (secs_q + off_ext) : (secs_q - off_ext);
        state_d  = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      type_count_q  <= '0;
      trans_count_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      type_count_q  <= type_count_d;
      trans_count_q <= trans_count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= in_i.op;
      secs_q <= in_i.seconds;
      uoff_q <= in_i.zone_offset;
      ti_q   <= in_i.type_index;
      post_q <= in_i.post_transition;
    end
    lo_q         <= lo_d;
    len_q        <= len_d;
    type_p_q     <= type_p_d;
    utc_p_q      <= utc_p_d;
    type_idx_q   <= type_idx_d;
    prior_type_q <= prior_type_d;
    ps_q         <= ps_d;
    status_q     <= status_d;
    res_q        <= res_d;
    off_q        <= off_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_res_q    <= res_q;
      out_off_q    <= off_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.result_seconds = out_res_q;
  assign out_o.found_offset   = out_off_q;

  // offset of each type
  tzl_ram #(
    .WIDTH (OFF_W),
    .DEPTH (MAX_TYPES)
  ) u_type_ram (
    .clk_i   (clk_i),
    .we_i    (type_we),
    .waddr_i (type_waddr),
    .wdata_i (uoff_q),
    .re_i    (type_re),
    .raddr_i (type_raddr),
    .rdata_o (type_rdata)
  );

  // transition entries: utc time, local time, type
  tzl_ram #(
    .WIDTH ($bits(trans_entry_t)),
    .DEPTH (MAX_TRANSITIONS)
  ) u_trans_ram (
    .clk_i   (clk_i),
    .we_i    (tr_we),
    .waddr_i (tr_waddr),
    .wdata_i (tr_wdata),
    .re_i    (tr_re),
    .raddr_i (tr_raddr),
    .rdata_o (tr_rdata)
  );

endmodule

[rtl/tzl_checker.sv]
module tzl_checker
  import tzl_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [STATUS_W-1:0] out_status_i,
  input logic [SEC_W-1:0]    out_result_seconds_i,
  input logic [OFF_W-1:0]    out_found_offset_i
);

  // a result stays offered until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_status_i) &&
      $stable(out_result_seconds_i) && $stable(out_found_offset_i))
    else $error("stalled result changed");

  // errors carry zero seconds and zero offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != ST_OK |->
      out_result_seconds_i == '0 && out_found_offset_i == '0)
    else $error("error result carries data");

  // one item at a time: no second item on the edge after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item accepted while busy");

endmodule

bind timezone_transition_lookup tzl_checker u_tzl_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_i.valid),
  .in_ready_i           (in_i.ready),
  .out_valid_i          (out_o.valid),
  .out_ready_i          (out_o.ready),
  .out_status_i         (out_o.status),
  .out_result_seconds_i (out_o.result_seconds),
  .out_found_offset_i   (out_o.found_offset)
);
